// File: hdl/channel_timer_allocator_assert.svh
// ---------------------------------------------------------------------------
// channel_timer_allocator assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef CHANNEL_TIMER_ALLOCATOR_ASSERT_SVH
`define CHANNEL_TIMER_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CTA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CTA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CTA_ASSERT_NOW(label, clk, rst, ante, cons)
`define CTA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hdl/cta_pkg.sv
// ---------------------------------------------------------------------------
// cta_pkg
// Shared constants, op codes and types of the channel timer allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package cta_pkg;

   localparam int MAX_CHANNELS     = 16;
   localparam int MAX_TIMERS       = 8;
   localparam int CHANNELS_DEFAULT = 16;
   localparam int TIMERS_DEFAULT   = 8;

   localparam int OP_W       = 2;
   localparam int CHAN_IN_W  = 8;
   localparam int CHAN_OUT_W = 4;
   localparam int COUNT_W    = 4;
   localparam int TIMER_IDX_W = 3;
   localparam int MAP_W      = MAX_CHANNELS * TIMER_IDX_W;

   localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
   localparam logic [OP_W-1:0] OP_RESERVE = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
   localparam logic [OP_W-1:0] OP_COUNT   = 2'd3;

   typedef struct packed {
      logic                 fire;
      logic [OP_W-1:0]      op;
      logic [CHAN_IN_W-1:0] channel;
   } cta_cmd_type;

   typedef struct packed {
      logic                  granted;
      logic [CHAN_OUT_W-1:0] channel_out;
      logic [COUNT_W-1:0]    free_timers;
   } cta_result_type;

endpackage

`default_nettype wire

// File: hdl/cta_channels.sv
// ---------------------------------------------------------------------------
// cta channel interfaces
// Valid/ready channels for requests, responses and the map register write.
// ---------------------------------------------------------------------------
`default_nettype none

interface cta_req_if;
   logic                          valid;
   logic                          ready;
   logic [cta_pkg::OP_W-1:0]      op;
   logic [cta_pkg::CHAN_IN_W-1:0] channel;
   modport source (output valid, op, channel, input ready);
   modport sink   (input valid, op, channel, output ready);
endinterface

interface cta_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           granted;
   logic [cta_pkg::CHAN_OUT_W-1:0] channel_out;
   logic [cta_pkg::COUNT_W-1:0]    free_timers;
   modport source (output valid, granted, channel_out, free_timers, input ready);
   modport sink   (input valid, granted, channel_out, free_timers, output ready);
endinterface

interface cta_csr_if;
   logic                      valid;
   logic                      ready;
   logic [cta_pkg::MAP_W-1:0] channel_timer_map;
   modport source (output valid, channel_timer_map, input ready);
   modport sink   (input valid, channel_timer_map, output ready);
endinterface

`default_nettype wire

// File: hdl/channel_timer_allocator.sv
// ---------------------------------------------------------------------------
// channel_timer_allocator
// First-fit allocator of output channels that share timers.
// ---------------------------------------------------------------------------
// A request beat lands in an input register, is resolved against the channel
// and timer used masks combinationally, and its response sits in an output
// register until taken. One request is accepted every cycle while responses
// drain. The masks update when a request leaves the input register, so
// back-to-back requests see each other's effect. The map register is to be
// written through the csr port only while no request is in flight; the block
// itself does not enforce this.
`default_nettype none
`include "channel_timer_allocator_assert.svh"

module channel_timer_allocator #(
   parameter int CHANNELS = cta_pkg::CHANNELS_DEFAULT,
   parameter int TIMERS   = cta_pkg::TIMERS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   cta_req_if.sink   req_bus,
   cta_rsp_if.source rsp_bus,
   cta_csr_if.sink   csr_bus
);

   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic [cta_pkg::OP_W-1:0]     s1_op_ff;
   logic [cta_pkg::CHAN_IN_W-1:0] s1_channel_ff;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   cta_pkg::cta_result_type      out_data_ff;
   logic [cta_pkg::MAP_W-1:0]    map_ff;
   logic [cta_pkg::MAP_W-1:0]    map_in;

   logic                         advance;
   logic                         fire;
   logic                         req_take;
   cta_pkg::cta_cmd_type         cmd;
   cta_pkg::cta_result_type      result;

   assign advance         = !out_valid_ff || rsp_bus.ready;
   assign fire            = s1_valid_ff && advance;
   assign req_bus.ready   = !s1_valid_ff || advance;
   assign req_take        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready   = 1'b1;

   assign cmd.fire    = fire;
   assign cmd.op      = s1_op_ff;
   assign cmd.channel = s1_channel_ff;

   cta_alloc #(
      .CHANNELS (CHANNELS),
      .TIMERS   (TIMERS)
   ) u_alloc (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .map    (map_ff),
      .result (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   assign map_in       = csr_bus.valid ? csr_bus.channel_timer_map : map_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         map_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         map_ff       <= map_in;
      end
   end

   // hold payloads unless a beat moves
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff      <= req_bus.op;
         s1_channel_ff <= req_bus.channel;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.granted     = out_data_ff.granted;
   assign rsp_bus.channel_out = out_data_ff.channel_out;
   assign rsp_bus.free_timers = out_data_ff.free_timers;

   `CTA_ASSERT_NOW(a_stall_full, clock, reset, !req_bus.ready, s1_valid_ff && out_valid_ff)
   `CTA_ASSERT_NEXT(a_fire_fills, clock, reset, fire, out_valid_ff)
   `CTA_ASSERT_NOW(a_count_range, clock, reset, out_valid_ff,
                   out_data_ff.free_timers <= cta_pkg::COUNT_W'(TIMERS))
   `CTA_ASSERT_NOW(a_chan_granted, clock, reset,
                   out_valid_ff && (out_data_ff.channel_out != '0), out_data_ff.granted)

endmodule

`default_nettype wire

// File: hdl/cta_alloc.sv
// ---------------------------------------------------------------------------
// cta_alloc
// Used masks and the first-fit select, reserve, release and free count.
// ---------------------------------------------------------------------------
`default_nettype none

module cta_alloc #(
   parameter int CHANNELS = cta_pkg::CHANNELS_DEFAULT,
   parameter int TIMERS   = cta_pkg::TIMERS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cta_pkg::cta_cmd_type       cmd,
   input  wire logic [cta_pkg::MAP_W-1:0]  map,
   output cta_pkg::cta_result_type         result
);

   logic [CHANNELS-1:0]                  chan_used_ff;
   logic [CHANNELS-1:0]                  chan_used_in;
   logic [cta_pkg::MAX_TIMERS-1:0]       timer_used_ff;
   logic [cta_pkg::MAX_TIMERS-1:0]       timer_used_in;

   logic [cta_pkg::MAX_CHANNELS-1:0]     chan16;
   logic [cta_pkg::MAX_CHANNELS-1:0]     chan16_next;
   logic [cta_pkg::MAX_TIMERS-1:0]       timer_next;
   logic [cta_pkg::MAX_CHANNELS-1:0]     free16;
   logic [cta_pkg::TIMER_IDX_W-1:0]      tidx [cta_pkg::MAX_CHANNELS];
   logic                                 found;
   logic [cta_pkg::CHAN_OUT_W-1:0]       sel;
   logic [cta_pkg::CHAN_OUT_W-1:0]       ch4;
   logic                                 in_range;
   logic [cta_pkg::COUNT_W-1:0]          n_free;

   always_comb begin
      chan16 = cta_pkg::MAX_CHANNELS'(chan_used_ff);
      for (int c = 0; c < cta_pkg::MAX_CHANNELS; c++) begin
         tidx[c]   = map[c*cta_pkg::TIMER_IDX_W +: cta_pkg::TIMER_IDX_W];
         free16[c] = (c < CHANNELS) && !chan16[c] && !timer_used_ff[tidx[c]];
      end
   end

   // lowest free channel wins
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int c = cta_pkg::MAX_CHANNELS - 1; c >= 0; c--) begin
         if (free16[c]) begin
            found = 1'b1;
            sel   = cta_pkg::CHAN_OUT_W'(c);
         end
      end
   end

   assign ch4      = cmd.channel[cta_pkg::CHAN_OUT_W-1:0];
   assign in_range = cmd.channel < cta_pkg::CHAN_IN_W'(CHANNELS);

   always_comb begin
      chan16_next        = chan16;
      timer_next         = timer_used_ff;
      result.granted     = 1'b0;
      result.channel_out = '0;
      case (cmd.op)
         cta_pkg::OP_ACQUIRE: begin
            if (found) begin
               chan16_next[sel]      = 1'b1;
               timer_next[tidx[sel]] = 1'b1;
               result.granted        = 1'b1;
               result.channel_out    = sel;
            end
         end
         cta_pkg::OP_RESERVE: begin
            if (in_range && free16[ch4]) begin
               chan16_next[ch4]      = 1'b1;
               timer_next[tidx[ch4]] = 1'b1;
               result.granted        = 1'b1;
            end
         end
         cta_pkg::OP_RELEASE: begin
            if (in_range) begin
               chan16_next[ch4]      = 1'b0;
               timer_next[tidx[ch4]] = 1'b0;
               result.granted        = 1'b1;
            end
         end
         cta_pkg::OP_COUNT: begin
            result.granted = 1'b1;
         end
         default: begin
            result.granted = 1'b1;
         end
      endcase

      // count timers below TIMERS only
      n_free = '0;
      for (int t = 0; t < cta_pkg::MAX_TIMERS; t++) begin
         if ((t < TIMERS) && !timer_next[t]) begin
            n_free = n_free + cta_pkg::COUNT_W'(1);
         end
      end
      result.free_timers = n_free;
   end

   assign chan_used_in  = cmd.fire ? CHANNELS'(chan16_next) : chan_used_ff;
   assign timer_used_in = cmd.fire ? timer_next : timer_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_used_ff  <= '0;
         timer_used_ff <= '0;
      end else begin
         chan_used_ff  <= chan_used_in;
         timer_used_ff <= timer_used_in;
      end
   end

endmodule

`default_nettype wire
